>>> src/first_fit_aligned_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit allocator unit
// Shared property forms, clocked on i_clk and held off while in reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_ALIGNED_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_ALIGNED_ALLOCATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Types, codes and helpers shared by the first-fit allocator modules.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int MAX_FREE_BLOCKS_DEF = 64;
    localparam int OFFSET_BITS_DEF     = 32;

    localparam logic [31:0] POOL_TOTAL_RST = 32'd1048576;
    localparam logic [15:0] DEF_ALIGN_RST  = 16'd16;

    // Command codes.
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_POOL_TOTAL = 1'b0;
    localparam logic CFG_DEF_ALIGN  = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] size_bytes;
        logic [15:0] align_request;
        logic [31:0] block_offset;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_offset;
        logic [31:0] used_bytes;
        logic [31:0] peak_bytes;
        logic [31:0] free_sum;
        logic [31:0] largest_free;
    } t_out_word;

    // Control for the row of list cells.
    typedef struct packed {
        logic shift;
        logic wr;
    } t_chain_ctl;

    function automatic logic [31:0] f_sat32(input logic [63:0] x);
        f_sat32 = (x > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

endpackage

>>> src/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One free-list entry. Takes its neighbor's entry on a shift, or new data
// when selected for a write.
// ----------------------------------------------------------------------------
module ffa_cell #(
    parameter int OB = ffa_pkg::OFFSET_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffa_pkg::t_chain_ctl i_ctl,
    input  logic                i_sel,
    input  logic [OB-1:0]       i_next_off,
    input  logic [OB-1:0]       i_next_size,
    input  logic [OB-1:0]       i_wr_off,
    input  logic [OB-1:0]       i_wr_size,
    output logic [OB-1:0]       o_off,
    output logic [OB-1:0]       o_size
);
    import ffa_pkg::*;

    logic [OB-1:0] r_off;
    logic [OB-1:0] r_size;

    // Reset leaves the single pool block; only the head cell is ever read then.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_size <= OB'(64'(POOL_TOTAL_RST));
        end else if (i_ctl.shift) begin
            r_off  <= i_next_off;
            r_size <= i_next_size;
        end else if (i_ctl.wr && i_sel) begin
            r_off  <= i_wr_off;
            r_size <= i_wr_size;
        end
    end

    assign o_off  = r_off;
    assign o_size = r_size;

endmodule

>>> src/ffa_mod_unit.sv
// ----------------------------------------------------------------------------
// ffa_mod_unit
// Bit-serial remainder of an offset by a 16-bit alignment, one dividend
// bit per cycle.
// ----------------------------------------------------------------------------
module ffa_mod_unit #(
    parameter int DW = ffa_pkg::OFFSET_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [15:0]   i_divisor,
    output logic          o_busy,
    output logic [15:0]   o_rem
);
    import ffa_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [15:0]   r_rem;
    logic [15:0]   r_dvs;
    logic [16:0]   n_trial;

    // Shift in the next dividend bit and subtract when the divisor fits.
    always_comb begin
        n_trial = {r_rem, r_dvd[DW-1]};
        if (n_trial >= {1'b0, r_dvs}) begin
            n_trial = n_trial - {1'b0, r_dvs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= n_trial[15:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

endmodule

>>> src/first_fit_aligned_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_aligned_allocator_unit
// First-fit free-list allocator with alignment and coalescing.
// ----------------------------------------------------------------------------
// The free list lives in a row of cells, head first. Every command makes one
// pass: each entry is popped off the head, rewritten as needed and pushed back
// at the tail, so the list is back in order when the pass ends and the free
// total and largest block are summed on the way. An allocate also runs the serial
// remainder unit on every entry it tests up to the fit. One command is handled
// at a time; the next word is taken while the last result waits.
// ----------------------------------------------------------------------------
`include "first_fit_aligned_allocator_unit_macros.svh"

module first_fit_aligned_allocator_unit #(
    parameter int MAX_FREE_BLOCKS = ffa_pkg::MAX_FREE_BLOCKS_DEF,
    parameter int OFFSET_BITS     = ffa_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ffa_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ffa_pkg::t_out_word o_out_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import ffa_pkg::*;

    localparam int N  = MAX_FREE_BLOCKS;
    localparam int OB = OFFSET_BITS;
    localparam int IW = $clog2(N);
    localparam int LW = $clog2(N + 1);
    localparam int WW = ((OB > 32) ? OB : 32) + 2;
    localparam logic [OB-1:0] OFS_MAX = {OB{1'b1}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_PUSH2 = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    // Configuration and control registers.
    logic [31:0]   r_pool_total;
    logic [15:0]   r_def_align;
    logic [2:0]    r_state;
    logic [1:0]    r_mode;
    logic [LW-1:0] r_live;
    logic [LW-1:0] r_rem_cnt;
    logic [LW-1:0] r_cnt0;
    logic          r_found;
    logic          r_ins;
    logic          r_have_e;
    logic          r_have_last;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [31:0]   r_used;
    logic [31:0]   r_peak;

    // Payload registers.
    logic [OB-1:0] r_cur_off, r_cur_size;
    logic [OB-1:0] r_last_off, r_last_size;
    logic [OB-1:0] r_q_off, r_q_size;
    logic [OB-1:0] r_foff, r_fsz;
    logic [31:0]   r_bytes;
    logic [15:0]   r_align;
    logic [1:0]    r_status;
    logic [31:0]   r_granted;
    logic [31:0]   r_total;
    logic [31:0]   r_largest;
    t_out_word     r_out_word;

    // Cell row nets.
    logic [OB-1:0] w_off  [N];
    logic [OB-1:0] w_size [N];
    t_chain_ctl    w_ctl;
    logic [IW-1:0] w_widx;
    logic [OB-1:0] w_wr_off, w_wr_size;

    logic          w_accept;
    logic          w_div_start, w_div_busy;
    logic [15:0]   w_div_rem;
    logic [15:0]   w_align_req;
    logic          w_full;

    // Entry evaluation results.
    logic          e1_push, e1_tail, e2_v;
    logic [OB-1:0] e1_off, e1_size, e2_off, e2_size;
    logic          ev_found, ev_ins, ev_full, ev_alloc_ok;
    logic [31:0]   ev_granted;
    logic [16:0]   pad;
    logic [WW-1:0] need, offw, rest;
    logic [OB-1:0] tail_off;
    logic          mn, mp;
    logic [OB+1:0] sum3, sum_p, sum_n;
    logic [OB:0]   f_end, l_end;

    assign w_accept    = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_full      = (r_cnt0 >= LW'(N));
    assign w_div_start = (r_state == S_POP) && (r_rem_cnt != '0) && (r_mode == MODE_ALLOC)
                         && !r_found;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_total <= POOL_TOTAL_RST;
            r_def_align  <= DEF_ALIGN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POOL_TOTAL: r_pool_total <= i_cfg_data;
                CFG_DEF_ALIGN:  r_def_align  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Row of list cells.
    for (genvar j = 0; j < N; j++) begin : g_cell
        ffa_cell #(.OB(OB)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_sel      (w_widx == IW'(j)),
            .i_next_off (w_off[(j + 1) % N]),
            .i_next_size(w_size[(j + 1) % N]),
            .i_wr_off   (w_wr_off),
            .i_wr_size  (w_wr_size),
            .o_off      (w_off[j]),
            .o_size     (w_size[j])
        );
    end

    ffa_mod_unit #(.DW(OB)) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_off[0]),
        .i_divisor (r_align),
        .o_busy    (w_div_busy),
        .o_rem     (w_div_rem)
    );

    // Evaluate the popped entry against the current command.
    always_comb begin
        e1_push     = 1'b0;
        e1_tail     = 1'b0;
        e1_off      = r_cur_off;
        e1_size     = r_cur_size;
        e2_v        = 1'b0;
        e2_off      = r_cur_off;
        e2_size     = r_cur_size;
        ev_found    = 1'b0;
        ev_ins      = 1'b0;
        ev_full     = 1'b0;
        ev_alloc_ok = 1'b0;
        pad         = (w_div_rem == '0) ? 17'd0 : (17'(r_align) - 17'(w_div_rem));
        need        = WW'(pad) + WW'(r_bytes);
        offw        = WW'(r_cur_off) + WW'(pad);
        rest        = WW'(r_cur_size) - need;
        tail_off    = OB'(offw + WW'(r_bytes));
        ev_granted  = 32'(offw);
        f_end       = (OB + 1)'(r_foff) + (OB + 1)'(r_fsz);
        l_end       = (OB + 1)'(r_last_off) + (OB + 1)'(r_last_size);
        mn          = r_have_e && (f_end == (OB + 1)'(r_cur_off));
        mp          = r_have_last && (l_end == (OB + 1)'(r_foff));
        sum3        = (OB + 2)'(r_last_size) + (OB + 2)'(r_fsz) + (OB + 2)'(r_cur_size);
        sum_p       = (OB + 2)'(r_last_size) + (OB + 2)'(r_fsz);
        sum_n       = (OB + 2)'(r_fsz) + (OB + 2)'(r_cur_size);
        if (r_mode == MODE_ALLOC && !r_found) begin
            if (WW'(r_cur_size) >= need) begin
                ev_found = 1'b1;
                if (pad != '0 && rest != '0) begin
                    if (w_full) begin
                        ev_full = 1'b1;
                        e1_push = 1'b1;
                    end else begin
                        e1_push     = 1'b1;
                        e1_size     = OB'(pad);
                        e2_v        = 1'b1;
                        e2_off      = tail_off;
                        e2_size     = OB'(rest);
                        ev_alloc_ok = 1'b1;
                    end
                end else if (pad != '0) begin
                    e1_push     = 1'b1;
                    e1_size     = OB'(pad);
                    ev_alloc_ok = 1'b1;
                end else if (rest != '0) begin
                    e1_push     = 1'b1;
                    e1_off      = tail_off;
                    e1_size     = OB'(rest);
                    ev_alloc_ok = 1'b1;
                end else begin
                    ev_alloc_ok = 1'b1;
                end
            end else begin
                e1_push = 1'b1;
            end
        end else if (r_mode == MODE_FREE && !r_ins && (!r_have_e || r_cur_off >= r_foff)) begin
            ev_ins = 1'b1;
            if (!mn && !mp && w_full) begin
                ev_full = 1'b1;
                e1_push = r_have_e;
            end else if (mn && mp) begin
                e1_tail = 1'b1;
                e1_off  = r_last_off;
                e1_size = (sum3 > (OB + 2)'(OFS_MAX)) ? OFS_MAX : OB'(sum3);
            end else if (mn) begin
                e1_push = 1'b1;
                e1_off  = r_foff;
                e1_size = (sum_n > (OB + 2)'(OFS_MAX)) ? OFS_MAX : OB'(sum_n);
            end else if (mp) begin
                e1_tail = 1'b1;
                e1_off  = r_last_off;
                e1_size = (sum_p > (OB + 2)'(OFS_MAX)) ? OFS_MAX : OB'(sum_p);
                e2_v    = r_have_e;
            end else begin
                e1_push = 1'b1;
                e1_off  = r_foff;
                e1_size = r_fsz;
                e2_v    = r_have_e;
            end
        end else begin
            e1_push = r_have_e;
        end
    end

    // Cell row control: shift on a pop, restore on a reset command, writes on push or tail merge.
    always_comb begin
        w_ctl.shift = (r_state == S_POP) && (r_rem_cnt != '0);
        w_ctl.wr    = 1'b0;
        w_widx      = r_live[IW-1:0];
        w_wr_off    = e1_off;
        w_wr_size   = e1_size;
        case (r_state)
            S_IDLE: begin
                w_ctl.wr  = w_accept && (i_in_word.command == CMD_RESET);
                w_widx    = '0;
                w_wr_off  = '0;
                w_wr_size = OB'(64'(r_pool_total));
            end
            S_EVAL: begin
                w_ctl.wr = e1_push || e1_tail;
                if (e1_tail) begin
                    w_widx = IW'(r_live - 1'b1);
                end
            end
            S_PUSH2: begin
                w_ctl.wr  = 1'b1;
                w_wr_off  = r_q_off;
                w_wr_size = r_q_size;
            end
            default: ;
        endcase
    end

    assign w_align_req = (i_in_word.align_request != '0) ? i_in_word.align_request
                                                          : r_def_align;

    // Result valid: held while stalled, set when a new result word is loaded.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
            n_out_valid = 1'b1;
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_NONE;
            r_live      <= LW'(1);
            r_rem_cnt   <= '0;
            r_cnt0      <= LW'(1);
            r_found     <= 1'b0;
            r_ins       <= 1'b0;
            r_have_e    <= 1'b0;
            r_have_last <= 1'b0;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_peak      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_found     <= 1'b0;
                        r_ins       <= 1'b0;
                        r_have_last <= 1'b0;
                        if (i_in_word.command == CMD_ALLOC && i_in_word.size_bytes != '0) begin
                            r_mode <= MODE_ALLOC;
                        end else if (i_in_word.command == CMD_FREE
                                     && OB'(64'(i_in_word.size_bytes)) != '0) begin
                            r_mode <= MODE_FREE;
                        end else begin
                            r_mode <= MODE_NONE;
                        end
                        if (i_in_word.command == CMD_RESET) begin
                            r_live    <= LW'(1);
                            r_cnt0    <= LW'(1);
                            r_rem_cnt <= LW'(1);
                            r_used    <= '0;
                            r_peak    <= '0;
                        end else begin
                            r_cnt0    <= r_live;
                            r_rem_cnt <= r_live;
                        end
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_rem_cnt != '0) begin
                        r_have_e  <= 1'b1;
                        r_live    <= r_live - 1'b1;
                        r_rem_cnt <= r_rem_cnt - 1'b1;
                        r_state   <= w_div_start ? S_DIV : S_EVAL;
                    end else if (r_mode == MODE_FREE && !r_ins) begin
                        r_have_e <= 1'b0;
                        r_state  <= S_EVAL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (ev_found) begin
                        r_found <= 1'b1;
                    end
                    if (ev_ins) begin
                        r_ins <= 1'b1;
                    end
                    if (e1_push) begin
                        r_live      <= r_live + 1'b1;
                        r_have_last <= 1'b1;
                    end
                    if (ev_alloc_ok) begin
                        r_used <= f_sat32(64'(r_used) + 64'(r_bytes));
                        if (f_sat32(64'(r_used) + 64'(r_bytes)) > r_peak) begin
                            r_peak <= f_sat32(64'(r_used) + 64'(r_bytes));
                        end
                    end
                    r_state <= e2_v ? S_PUSH2 : S_POP;
                end
                S_PUSH2: begin
                    r_live      <= r_live + 1'b1;
                    r_have_last <= 1'b1;
                    r_state     <= S_POP;
                end
                S_FIN: begin
                    if (r_mode == MODE_FREE && r_status == ST_OK
                        && 64'(r_used) >= 64'(r_fsz)) begin
                        r_used <= 32'(64'(r_used) - 64'(r_fsz));
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Command fields, entry buffers and running sums.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_bytes   <= i_in_word.size_bytes;
                    r_foff    <= OB'(64'(i_in_word.block_offset));
                    r_fsz     <= OB'(64'(i_in_word.size_bytes));
                    r_align   <= (w_align_req == '0) ? 16'd1 : w_align_req;
                    r_status  <= ST_OK;
                    r_granted <= '0;
                    r_total   <= '0;
                    r_largest <= '0;
                end
            end
            S_POP: begin
                r_cur_off  <= w_off[0];
                r_cur_size <= w_size[0];
            end
            S_EVAL: begin
                if (ev_full) begin
                    r_status <= ST_FULL;
                end
                if (ev_alloc_ok) begin
                    r_granted <= ev_granted;
                end
                if (e1_push && r_have_last) begin
                    r_total <= f_sat32(64'(r_total) + 64'(f_sat32(64'(r_last_size))));
                    if (f_sat32(64'(r_last_size)) > r_largest) begin
                        r_largest <= f_sat32(64'(r_last_size));
                    end
                end
                if (e1_push || e1_tail) begin
                    r_last_off  <= e1_off;
                    r_last_size <= e1_size;
                end
                r_q_off  <= e2_off;
                r_q_size <= e2_size;
            end
            S_PUSH2: begin
                if (r_have_last) begin
                    r_total <= f_sat32(64'(r_total) + 64'(f_sat32(64'(r_last_size))));
                    if (f_sat32(64'(r_last_size)) > r_largest) begin
                        r_largest <= f_sat32(64'(r_last_size));
                    end
                end
                r_last_off  <= r_q_off;
                r_last_size <= r_q_size;
            end
            S_FIN: begin
                if (r_mode == MODE_ALLOC && !r_found) begin
                    r_status <= ST_NOFIT;
                end
                if (r_have_last) begin
                    r_total <= f_sat32(64'(r_total) + 64'(f_sat32(64'(r_last_size))));
                    if (f_sat32(64'(r_last_size)) > r_largest) begin
                        r_largest <= f_sat32(64'(r_last_size));
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out_word.status       <= r_status;
                    r_out_word.alloc_offset <= (r_status == ST_OK) ? r_granted : '0;
                    r_out_word.used_bytes   <= r_used;
                    r_out_word.peak_bytes   <= r_peak;
                    r_out_word.free_sum     <= r_total;
                    r_out_word.largest_free <= r_largest;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks on the list bookkeeping and the sequencer.
    `FFA_ASSERT_NOW(a_live_bound, 1'b1, r_live <= LW'(N), "free list holds more than its cells")
    `FFA_ASSERT_NOW(a_idle_no_rem, r_state == S_IDLE, r_rem_cnt == '0, "pass left entries unvisited")
    `FFA_ASSERT_NEXT(a_accept_busy, w_accept, r_state == S_POP, "accepted word did not start a pass")
    `FFA_ASSERT_NOW(a_peak_used, r_state == S_IDLE, r_peak >= r_used, "peak count below used count")

endmodule

>>> sim/ffa_checker.sv
// ----------------------------------------------------------------------------
// First-fit allocator checker
// Watches the command, result and register channels, keeps its own copy of
// the free list, and compares each result word with the predicted one.
// ----------------------------------------------------------------------------
module ffa_checker
    import ffa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results
);

    localparam int NBLK = 64;

    // Shadow allocator state.
    logic [31:0] pool_size;
    logic [15:0] dflt_align;
    logic [31:0] blk_ofs [NBLK];
    logic [31:0] blk_len [NBLK];
    int          blk_cnt;
    logic [31:0] used_sum;
    logic [31:0] peak_sum;

    t_out_word expected_results[$];

    function automatic void restore_pool();
        blk_cnt = 1;
        blk_ofs[0] = 0;
        blk_len[0] = pool_size;
        used_sum = 0;
        peak_sum = 0;
    endfunction

    function automatic void remove_blk(int i);
        for (int k = i; k < blk_cnt - 1; k++) begin
            blk_ofs[k] = blk_ofs[k+1];
            blk_len[k] = blk_len[k+1];
        end
        blk_cnt--;
    endfunction

    function automatic void open_blk(int i);
        for (int k = blk_cnt; k > i; k--) begin
            blk_ofs[k] = blk_ofs[k-1];
            blk_len[k] = blk_len[k-1];
        end
        blk_cnt++;
    endfunction

    function automatic logic [31:0] sat_add(logic [63:0] x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    // First-fit allocate; returns the status and the granted offset.
    function automatic logic [1:0] alloc_words(logic [31:0] nbytes, logic [15:0] areq,
                                               output logic [31:0] granted);
        logic [63:0] align, pad, need, rest, start;
        granted = 0;
        if (nbytes == 0) return ST_OK;
        align = (areq != 0) ? areq : dflt_align;
        if (align == 0) align = 1;
        for (int i = 0; i < blk_cnt; i++) begin
            start = blk_ofs[i];
            pad = (align - (start % align)) % align;
            need = pad + nbytes;
            if (blk_len[i] < need) continue;
            rest = blk_len[i] - need;
            if (pad > 0 && rest > 0) begin
                if (blk_cnt >= NBLK) return ST_FULL;
                open_blk(i + 1);
                blk_len[i] = pad;
                blk_ofs[i+1] = start + pad + nbytes;
                blk_len[i+1] = rest;
            end else if (pad > 0) begin
                blk_len[i] = pad;
            end else if (rest > 0) begin
                blk_ofs[i] = start + nbytes;
                blk_len[i] = rest;
            end else begin
                remove_blk(i);
            end
            used_sum = sat_add({32'd0, used_sum} + nbytes);
            if (used_sum > peak_sum) peak_sum = used_sum;
            granted = start + pad;
            return ST_OK;
        end
        return ST_NOFIT;
    endfunction

    // Free with coalescing into the next and previous neighbors.
    function automatic logic [1:0] free_words(logic [31:0] ofs, logic [31:0] sz);
        int  p;
        bit  mn, mp;
        if (sz == 0) return ST_OK;
        p = 0;
        while (p < blk_cnt && blk_ofs[p] < ofs) p++;
        mn = (p < blk_cnt) && ({32'd0, ofs} + sz == {32'd0, blk_ofs[p]});
        mp = (p > 0) && ({32'd0, blk_ofs[p-1]} + blk_len[p-1] == {32'd0, ofs});
        if (!mn && !mp && blk_cnt >= NBLK) return ST_FULL;
        if (mn && mp) begin
            blk_len[p-1] = sat_add({32'd0, blk_len[p-1]} + sz + blk_len[p]);
            remove_blk(p);
        end else if (mn) begin
            blk_ofs[p] = ofs;
            blk_len[p] = sat_add({32'd0, sz} + blk_len[p]);
        end else if (mp) begin
            blk_len[p-1] = sat_add({32'd0, blk_len[p-1]} + sz);
        end else begin
            open_blk(p);
            blk_ofs[p] = ofs;
            blk_len[p] = sz;
        end
        if (used_sum >= sz) used_sum -= sz;
        return ST_OK;
    endfunction

    function automatic t_out_word predict_result(t_in_word w);
        t_out_word   r;
        logic [31:0] granted;
        logic [63:0] total;
        logic [31:0] largest;
        granted = 0;
        r.status = ST_OK;
        case (w.command)
            CMD_ALLOC: r.status = alloc_words(w.size_bytes, w.align_request, granted);
            CMD_FREE:  r.status = free_words(w.block_offset, w.size_bytes);
            CMD_RESET: restore_pool();
            default: ;
        endcase
        total = 0;
        largest = 0;
        for (int i = 0; i < blk_cnt; i++) begin
            total += blk_len[i];
            if (blk_len[i] > largest) largest = blk_len[i];
        end
        r.alloc_offset = (r.status == ST_OK) ? granted : 32'd0;
        r.used_bytes   = used_sum;
        r.peak_bytes   = peak_sum;
        r.free_sum     = sat_add(total);
        r.largest_free = largest;
        return r;
    endfunction

    // Predict on accepted command words, compare on accepted result words.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            pool_size = POOL_TOTAL_RST;
            dflt_align = DEF_ALIGN_RST;
            restore_pool();
            expected_results.delete();
            o_fail_count <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_POOL_TOTAL) pool_size = i_cfg_data;
                else dflt_align = i_cfg_data[15:0];
            end
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word %h", i_out_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_out_word) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch: exp st=%0d ofs=%h used=%h peak=%h tot=%h big=%h",
                                want.status, want.alloc_offset, want.used_bytes,
                                want.peak_bytes, want.free_sum, want.largest_free);
                            $display("          got st=%0d ofs=%h used=%h peak=%h tot=%h big=%h",
                                i_out_word.status, i_out_word.alloc_offset,
                                i_out_word.used_bytes, i_out_word.peak_bytes,
                                i_out_word.free_sum, i_out_word.largest_free);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.insert(expected_results.size(), predict_result(i_in_word));
            o_pending <= expected_results.size();
        end
    end

endmodule

>>> sim/tb_first_fit_aligned_allocator_unit.sv
// ----------------------------------------------------------------------------
// First-fit allocator testbench
// Drives directed and random allocate, free and reset commands under random
// bursts and receiver stalls, rewrites both registers between phases, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_first_fit_aligned_allocator_unit;
    import ffa_pkg::*;

    localparam int LIMIT = 20_000_000;
    localparam int SETTLE = 64 * 36 + 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count, pending, results;
    int          cycles;
    bit          long_hold;
    int          stall_mode;

    // Live allocations kept for well-formed frees.
    logic [31:0] live_ofs[$];
    logic [31:0] live_len[$];

    first_fit_aligned_allocator_unit DUT (.*);

    ffa_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_word(i_in_word),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stall pattern, with an occasional long hold.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 0;
        else if (long_hold) i_out_stall <= 1;
        else case (stall_mode)
            0: i_out_stall <= 0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) < 6);
        endcase
    end

    task automatic send_word(t_in_word w);
        i_in_word <= w;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        i_in_valid <= 0;
        n = $urandom_range(0, 7);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic t_in_word make_word(logic [1:0] c, logic [31:0] s,
                                           logic [15:0] a, logic [31:0] o);
        t_in_word w;
        w.command = c;
        w.size_bytes = s;
        w.align_request = a;
        w.block_offset = o;
        return w;
    endfunction

    // Mostly well-formed allocate and free traffic; some noise.
    function automatic t_in_word random_word(logic [31:0] pool);
        int          pick;
        int          k;
        logic [31:0] s;
        logic [15:0] a;
        t_in_word    w;
        pick = $urandom_range(0, 99);
        a = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'(1 << $urandom_range(0, 8));
        if ($urandom_range(0, 19) == 0) a = 16'($urandom);
        if (pick < 45) begin
            s = $urandom_range(1, 300);
            if ($urandom_range(0, 9) == 0) s = $urandom_range(1, pool > 0 ? pool : 1);
            if ($urandom_range(0, 49) == 0) s = $urandom;
            return make_word(CMD_ALLOC, s, a, $urandom);
        end else if (pick < 85 && live_ofs.size() != 0) begin
            k = $urandom_range(0, live_ofs.size() - 1);
            s = live_len[k];
            w = make_word(CMD_FREE, s, 16'($urandom), live_ofs[k]);
            live_ofs.delete(k);
            live_len.delete(k);
            return w;
        end else if (pick < 93) begin
            return make_word(CMD_FREE, $urandom, 16'($urandom), $urandom);
        end else if (pick < 96) begin
            return make_word(CMD_RESET, $urandom, 16'($urandom), $urandom);
        end else begin
            return make_word(CMD_UNUSED, $urandom, 16'($urandom), $urandom);
        end
    endfunction

    // Remember granted blocks from the result stream for later frees.
    t_in_word sent_words[$];
    always @(posedge i_clk) begin
        t_in_word w;
        if (i_rst_n && i_in_valid && !o_in_stall) sent_words.insert(sent_words.size(), i_in_word);
        if (i_rst_n && o_out_valid && !i_out_stall && sent_words.size() != 0) begin
            w = sent_words.pop_front();
            if (w.command == CMD_RESET) begin
                live_ofs.delete();
                live_len.delete();
            end else if (w.command == CMD_ALLOC && o_out_word.status == ST_OK
                         && w.size_bytes != 0 && w.size_bytes < 32'h0010_0000) begin
                live_ofs.insert(live_ofs.size(), o_out_word.alloc_offset);
                live_len.insert(live_len.size(), w.size_bytes);
            end
        end
    end

    task automatic random_phase(int count, logic [31:0] pool);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0) begin
                send_word(random_word(pool));
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) idle_gap();
        end
    endtask

    initial begin
        logic [31:0] pools[4];
        logic [15:0] aligns[4];
        pools = '{32'd1048576, 32'hFFFF_FFFF, 32'd0, 32'd4096};
        aligns = '{16'd0, 16'hFFFF, 16'd1, 16'd64};
        cycles = 0;
        long_hold = 0;
        stall_mode = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_word = '0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_POOL_TOTAL;
        i_cfg_data = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: extremes, every command and the special cases.
        send_word(make_word(CMD_ALLOC, 0, 0, 0));
        send_word(make_word(CMD_FREE, 0, 0, 32'h100));
        send_word(make_word(CMD_ALLOC, 100, 0, 0));
        send_word(make_word(CMD_ALLOC, 1, 16'd1, 0));
        send_word(make_word(CMD_ALLOC, 50, 16'hFFFF, 0));
        send_word(make_word(CMD_ALLOC, 32'hFFFF_FFFF, 16'd8, 0));
        send_word(make_word(CMD_FREE, 100, 0, 0));
        send_word(make_word(CMD_FREE, 1, 0, 112));
        send_word(make_word(CMD_FREE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_word(make_word(CMD_FREE, 32'd500, 0, 32'h0020_0000));
        send_word(make_word(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_word(make_word(CMD_RESET, 0, 0, 0));
        send_word(make_word(CMD_ALLOC, 32'h0010_0000, 16'd0, 0));
        send_word(make_word(CMD_FREE, 32'h0010_0000, 0, 0));
        // Fill the list with separated holes, then again past its capacity until it reports full.
        for (int i = 0; i < 10; i++) begin
            send_word(make_word(CMD_ALLOC, 8, 16'd16, 0));
            send_word(make_word(CMD_ALLOC, 8, 16'd16, 0));
        end
        send_word(make_word(CMD_RESET, 0, 0, 0));
        stall_mode = 1;
        for (int i = 0; i < 70; i++) send_word(make_word(CMD_ALLOC, 8, 16'd16, 0));
        for (int i = 0; i < 70; i++) send_word(make_word(CMD_FREE, 4, 0, 32'(i * 32)));
        send_word(make_word(CMD_RESET, 0, 0, 0));
        drain_results();

        // Long receiver hold while the sender keeps offering.
        fork
            begin
                long_hold = 1;
                repeat (3000) @(negedge i_clk);
                long_hold = 0;
            end
            begin
                random_phase(30, 32'd1048576);
                i_in_valid <= 0;
            end
        join
        drain_results();

        // Random phases across register settings.
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_POOL_TOTAL, pools[ph]);
            write_reg(CFG_DEF_ALIGN, {16'd0, aligns[ph]});
            stall_mode = ph % 3;
            send_word(make_word(CMD_RESET, 0, 0, 0));
            random_phase(240, pools[ph]);
            drain_results();
        end

        $display("Covered %0d results over four pool and alignment settings,", results);
        $display("with list-full, no-fit, coalescing and long receiver holds.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
